### hdl/ppl_pkg.sv
// Package for the polyline path length block: widths, command and status types.
package ppl_pkg;

  localparam int COORD_W = 16;
  localparam int ACC_W   = 32;
  localparam int CNT_W   = 16;
  localparam int MAG_W   = COORD_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 1;
  localparam int ROOT_W  = (SUM_W + 1) / 2;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int WREM_W  = REM_W + 2;
  localparam int ITER_W  = $clog2(ROOT_W);

  localparam logic [ACC_W-1:0]  ACC_MAX = {ACC_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX = {CNT_W{1'b1}};
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ROOT_W - 1);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic load;
    logic diff;
    logic square;
    logic sum;
    logic root_step;
    logic accum;
    logic finish;
  } ppl_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic last;
    logic out_free;
  } ppl_stat_t;

endpackage

### hdl/ppl_ifs.sv
// Stream interfaces for points in and path results out.
interface ppl_point_if;
  import ppl_pkg::*;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface

interface ppl_result_if;
  import ppl_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACC_W-1:0] path_length;
  logic [CNT_W-1:0] point_count;
  logic             length_saturated;

  modport source (output valid, output path_length, output point_count,
                  output length_saturated, input ready);
  modport sink   (input valid, input path_length, input point_count,
                  input length_saturated, output ready);
endinterface

### hdl/ppl_datapath.sv
// Datapath: point registers, differences, squares, shared square root, accumulators.
module ppl_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  ppl_pkg::ppl_cmd_t  cmd,
  output ppl_pkg::ppl_stat_t stat,
  input  logic               ready,
  ppl_point_if.sink          in_ch,
  ppl_result_if.source       out_ch
);
  import ppl_pkg::*;

  coord_t              cur_x_r, cur_y_r, prev_x_r, prev_y_r;
  logic                last_r, have_prev_r;
  logic [MAG_W-1:0]    ax_r, ay_r;
  logic [SQ_W-1:0]     sx_r, sy_r;
  logic [RAD_W-1:0]    rad_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [ACC_W-1:0]    acc_r;
  logic                sat_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                out_valid_r;
  logic [ACC_W-1:0]    out_len_r;
  logic [CNT_W-1:0]    out_cnt_r;
  logic                out_sat_r;

  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W:0]        dx_abs, dy_abs;
  logic [WREM_W-1:0]       rem_sh, trial, rem_diff;
  logic [ACC_W:0]          acc_sum;
  logic [CNT_W-1:0]        cnt_inc;
  logic                    emit;

  assign in_ch.ready = ready;
  assign dx = {cur_x_r[COORD_W-1], cur_x_r} - {prev_x_r[COORD_W-1], prev_x_r};
  assign dy = {cur_y_r[COORD_W-1], cur_y_r} - {prev_y_r[COORD_W-1], prev_y_r};
  assign dx_abs = dx[COORD_W] ? (COORD_W+1)'(0) - dx : dx;
  assign dy_abs = dy[COORD_W] ? (COORD_W+1)'(0) - dy : dy;

  // one result bit per step: bring down two radicand bits, try root*4+1
  assign rem_sh   = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial    = {{(WREM_W-ROOT_W-2){1'b0}}, root_r, 2'b01};
  assign rem_diff = rem_sh - trial;

  assign acc_sum = {1'b0, acc_r} + {{(ACC_W+1-ROOT_W){1'b0}}, root_r};
  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_W'(1);
  assign emit    = cmd.finish && last_r;

  assign stat.have_prev = have_prev_r;
  assign stat.last      = last_r;
  assign stat.out_free  = !out_valid_r || out_ch.ready;

  assign out_ch.valid            = out_valid_r;
  assign out_ch.path_length      = out_len_r;
  assign out_ch.point_count      = out_cnt_r;
  assign out_ch.length_saturated = out_sat_r;

  // payload pipeline
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x_r <= in_ch.point_x;
      cur_y_r <= in_ch.point_y;
      last_r  <= in_ch.last_point;
    end
    if (cmd.diff) begin
      ax_r <= dx_abs[MAG_W-1:0];
      ay_r <= dy_abs[MAG_W-1:0];
    end
    if (cmd.square) begin
      sx_r <= SQ_W'(ax_r) * SQ_W'(ax_r);
      sy_r <= SQ_W'(ay_r) * SQ_W'(ay_r);
    end
    if (cmd.sum) begin
      rad_r  <= RAD_W'({1'b0, sx_r} + {1'b0, sy_r});
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.root_step) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_diff[REM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[REM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
    if (emit) begin
      out_len_r <= acc_r;
      out_cnt_r <= cnt_inc;
      out_sat_r <= sat_r;
    end
  end

  // path state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      have_prev_r <= 1'b0;
      acc_r       <= '0;
      sat_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accum) begin
        if (acc_sum[ACC_W]) begin
          acc_r <= ACC_MAX;
          sat_r <= 1'b1;
        end else begin
          acc_r <= acc_sum[ACC_W-1:0];
        end
      end
      if (cmd.finish) begin
        if (last_r) begin
          prev_x_r    <= '0;
          prev_y_r    <= '0;
          have_prev_r <= 1'b0;
          acc_r       <= '0;
          sat_r       <= 1'b0;
          cnt_r       <= '0;
        end else begin
          prev_x_r    <= cur_x_r;
          prev_y_r    <= cur_y_r;
          have_prev_r <= 1'b1;
          cnt_r       <= cnt_inc;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

### hdl/ppl_ctrl.sv
// Controller: sequences one point through difference, squares, root and accumulate.
module ppl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ppl_pkg::ppl_stat_t stat,
  output ppl_pkg::ppl_cmd_t  cmd
);
  import ppl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIFF, S_SQUARE, S_SUM, S_ROOT, S_ACCUM, S_FINISH
  } state_t;

  state_t           state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = stat.have_prev ? S_DIFF : S_FINISH;
        end
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        iter_nxt  = '0;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        iter_nxt      = iter_r + ITER_W'(1);
        if (iter_r == ITER_LAST) begin
          state_nxt = S_ACCUM;
        end
      end
      S_ACCUM: begin
        cmd.accum = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // a last point waits here until the result register can take it
        if (!stat.last || stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

endmodule

### hdl/polyline_path_length.sv
// Polyline path length: top level joining controller and datapath.
//
// in_ch carries one point per transfer (point_x, point_y signed, 4 fraction
// bits, last_point marks the end of a path). out_ch carries one result per
// path: path_length (saturating sum of floor(sqrt(dx^2+dy^2))), point_count
// (saturating at 65535) and length_saturated.
// Each point is processed alone. The first point of a path goes through load
// and finish only. Every later point goes through load, difference, squares,
// radicand, 17 steps of the bit-serial square root (one root bit per cycle,
// sized for a 33-bit sum of squares), accumulate, and a finish step that
// updates the count and previous point.
// The result register is loaded in the finish cycle of a last point and is
// visible on out_ch the cycle after. If an earlier result has not been taken
// yet, a last point holds in the finish state and in_ch.ready stays low until
// the result register frees up; the register itself lets the next path begin
// while a result waits.
// Synchronous active-low reset clears the path state and drops out_ch.valid.
module polyline_path_length (
  input  logic         clk,
  input  logic         rst_n,
  ppl_point_if.sink    in_ch,
  ppl_result_if.source out_ch
);
  import ppl_pkg::*;

  ppl_cmd_t  cmd;
  ppl_stat_t stat;
  logic      ready;

  ppl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ppl_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .stat   (stat),
    .ready  (ready),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

### bench/tb_polyline_path_length.sv
`timescale 1ns / 100ps
// Testbench for polyline_path_length: points streamed in, path totals checked against a predictor.
module tb_polyline_path_length;
  import ppl_pkg::*;

  typedef enum int {MOVE_ANY, MOVE_NEAR, MOVE_CORNER} move_style_t;

  typedef struct {
    coord_t      x;
    coord_t      y;
    logic        last;
    int unsigned gap;
    bit          settle;   // hold this point back until no result is owed
  } point_item_t;

  typedef struct {
    logic [ACC_W-1:0] length;
    logic [CNT_W-1:0] count;
    logic             sat;
  } path_result_t;

  localparam coord_t CORNER [5] = '{16'sh8000, 16'shFFFF, 16'sh0000, 16'sh0001, 16'sh7FFF};

  logic clk;
  logic rst_n;

  ppl_point_if  pt_if ();
  ppl_result_if res_if ();

  polyline_path_length DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pt_if),
    .out_ch (res_if)
  );

  point_item_t  pending_points [$];
  path_result_t expected_paths [$];
  point_item_t  cur_point;
  int unsigned  points_total;
  int unsigned  points_sent;
  int unsigned  error_count;
  int unsigned  gap_left;
  bit           gap_loaded;
  int unsigned  stall_left;
  int unsigned  send_quiet;
  int unsigned  recv_quiet;

  // running state of the path being built
  coord_t           trail_x;
  coord_t           trail_y;
  bit               trail_started;
  logic [ACC_W-1:0] trail_len;
  logic             trail_sat;
  logic [CNT_W-1:0] trail_count;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    pt_if.valid = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    pt_if.last_point = 1'b0;
    res_if.ready = 1'b0;
    fork
      forever #2 clk = ~clk;
      begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
      end
    join
  end

  initial begin
    #2_000_000;
    $display("tb_polyline_path_length: errors");
    $finish;
  end

  function automatic longint unsigned segment_root(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    longint            dx;
    longint            dy;
    longint unsigned   sq;
    longint unsigned   root;
    longint unsigned   trial;
    dx = longint'(x1) - longint'(x0);
    dy = longint'(y1) - longint'(y0);
    sq = longint'(dx * dx) + longint'(dy * dy);
    root = 0;
    // 33-bit radicand, so the root fits in 17 bits
    for (int b = 17; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sq)
        root = trial;
    end
    return root;
  endfunction

  task automatic track_point(point_item_t p);
    longint unsigned seg;
    if (trail_started) begin
      seg = segment_root(trail_x, trail_y, p.x, p.y);
      if (seg > 64'(ACC_MAX) - 64'(trail_len)) begin
        trail_len = ACC_MAX;
        trail_sat = 1'b1;
      end else begin
        trail_len = trail_len + ACC_W'(seg);
      end
    end
    if (trail_count != CNT_MAX)
      trail_count++;
    trail_x = p.x;
    trail_y = p.y;
    trail_started = 1'b1;
    if (p.last) begin
      expected_paths.push_back('{length: trail_len, count: trail_count, sat: trail_sat});
      trail_x = '0;
      trail_y = '0;
      trail_started = 1'b0;
      trail_len = '0;
      trail_sat = 1'b0;
      trail_count = '0;
    end
  endtask

  function automatic int unsigned pick_gap();
    if (send_quiet != 0) begin
      send_quiet--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      send_quiet = $urandom_range(5, 30);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  task automatic push_point(coord_t x, coord_t y, logic last, int unsigned gap, bit settle);
    pending_points.push_back('{x: x, y: y, last: last, gap: gap, settle: settle});
  endtask

  task automatic add_path(int unsigned n, move_style_t style, bit settle);
    coord_t x;
    coord_t y;
    x = coord_t'($urandom_range(0, 65535));
    y = coord_t'($urandom_range(0, 65535));
    for (int unsigned i = 0; i < n; i++) begin
      case (style)
        MOVE_ANY: begin
          x = coord_t'($urandom_range(0, 65535));
          y = coord_t'($urandom_range(0, 65535));
        end
        MOVE_NEAR: begin
          x = x + coord_t'($urandom_range(0, 64)) - 16'sd32;
          y = y + coord_t'($urandom_range(0, 64)) - 16'sd32;
        end
        default: begin
          x = CORNER[$urandom_range(0, 4)];
          y = CORNER[$urandom_range(0, 4)];
        end
      endcase
      push_point(x, y, i == n - 1, pick_gap(), settle && i == 0);
    end
  endtask

  // driver: one point in flight, gap counted before each new point
  always @(posedge clk) begin
    logic drive_next;
    if (!rst_n) begin
      pt_if.valid <= 1'b0;
      gap_left = 0;
      gap_loaded = 1'b0;
    end else begin
      drive_next = pt_if.valid;
      if (pt_if.valid && pt_if.ready) begin
        track_point(cur_point);
        points_sent++;
        drive_next = 1'b0;
      end
      if (!drive_next && pending_points.size() != 0) begin
        if (!gap_loaded) begin
          gap_left = pending_points[0].gap;
          gap_loaded = 1'b1;
        end
        if (gap_left != 0) begin
          gap_left--;
        end else if (!pending_points[0].settle || expected_paths.size() == 0) begin
          cur_point = pending_points.pop_front();
          gap_loaded = 1'b0;
          pt_if.point_x <= cur_point.x;
          pt_if.point_y <= cur_point.y;
          pt_if.last_point <= cur_point.last;
          drive_next = 1'b1;
        end
      end
      pt_if.valid <= drive_next;
    end
  end

  // monitor: check each result transfer, then stall ready for a drawn spell
  always @(posedge clk) begin
    path_result_t want;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_paths.size() == 0) begin
          $display("%0t: unexpected result length %0d count %0d sat %0b", $time,
                   res_if.path_length, res_if.point_count, res_if.length_saturated);
          error_count++;
        end else begin
          want = expected_paths.pop_front();
          if (res_if.path_length !== want.length) begin
            $display("%0t: path_length expected %0d got %0d", $time, want.length,
                     res_if.path_length);
            error_count++;
          end
          if (res_if.point_count !== want.count) begin
            $display("%0t: point_count expected %0d got %0d", $time, want.count,
                     res_if.point_count);
            error_count++;
          end
          if (res_if.length_saturated !== want.sat) begin
            $display("%0t: length_saturated expected %0b got %0b", $time, want.sat,
                     res_if.length_saturated);
            error_count++;
          end
        end
        if (recv_quiet != 0) begin
          recv_quiet--;
          stall_left = 0;
        end else if ($urandom_range(0, 9) == 0) begin
          recv_quiet = $urandom_range(5, 20);
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 19);
        end
      end else if (stall_left != 0) begin
        stall_left--;
      end
      res_if.ready <= (stall_left == 0);
    end
  end

  initial begin
    int unsigned rand_points;
    int unsigned n;
    int unsigned paths;
    bit          settle;
    error_count = 0;
    points_sent = 0;
    send_quiet = 0;
    recv_quiet = 0;
    trail_x = '0;
    trail_y = '0;
    trail_started = 1'b0;
    trail_len = '0;
    trail_sat = 1'b0;
    trail_count = '0;

    // single-point paths
    push_point(16'sh0000, 16'sh0000, 1'b1, pick_gap(), 1'b0);
    push_point(16'sh8000, 16'sh7FFF, 1'b1, pick_gap(), 1'b0);
    // longest possible segment
    push_point(16'sh8000, 16'sh8000, 1'b0, pick_gap(), 1'b0);
    push_point(16'sh7FFF, 16'sh7FFF, 1'b1, pick_gap(), 1'b0);
    push_point(16'sh7FFF, 16'sh8000, 1'b0, pick_gap(), 1'b0);
    push_point(16'sh8000, 16'sh7FFF, 1'b0, pick_gap(), 1'b0);
    push_point(16'sh0000, 16'sh0000, 1'b1, pick_gap(), 1'b0);
    // zero-length segment
    push_point(16'sh0005, 16'sh0005, 1'b0, pick_gap(), 1'b0);
    push_point(16'sh0005, 16'sh0005, 1'b1, pick_gap(), 1'b0);
    // exact roots, then a rounded-down one
    push_point(16'sh0000, 16'sh0000, 1'b0, pick_gap(), 1'b0);
    push_point(16'sh0003, 16'sh0004, 1'b0, pick_gap(), 1'b0);
    push_point(-16'sh0003, -16'sh0004, 1'b0, pick_gap(), 1'b0);
    push_point(-16'sh0002, -16'sh0003, 1'b1, pick_gap(), 1'b0);
    // along one axis only
    push_point(16'sh8000, 16'sh0000, 1'b0, pick_gap(), 1'b0);
    push_point(16'sh7FFF, 16'sh0000, 1'b0, pick_gap(), 1'b0);
    push_point(16'sh7FFF, 16'sh8000, 1'b1, pick_gap(), 1'b0);

    // a longer path bouncing between opposite corners, back to back
    for (int unsigned i = 0; i < 100; i++) begin
      if (i[0])
        push_point(16'sh7FFF, 16'sh7FFF, i == 99, 0, 1'b0);
      else
        push_point(16'sh8000, 16'sh8000, 1'b0, 0, 1'b0);
    end
    // state must be clear again afterwards
    push_point(16'sh0001, 16'sh0001, 1'b1, pick_gap(), 1'b0);

    rand_points = 0;
    paths = 0;
    while (rand_points < 1180) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      settle = (paths == 60) || ($urandom_range(0, 49) == 0);
      add_path(n, move_style_t'($urandom_range(0, 2)), settle);
      rand_points += n;
      paths++;
    end
    points_total = pending_points.size();

    do
      @(negedge clk);
    while (points_sent != points_total || expected_paths.size() != 0);
    repeat (40) @(negedge clk);

    if (error_count == 0 && expected_paths.size() == 0)
      $display("tb_polyline_path_length: clean");
    else
      $display("tb_polyline_path_length: errors");
    $finish;
  end

endmodule
